### sv/awspg_pkg.sv
// Shared constants for the ADC window sum, peak check and gain block.
`default_nettype none

package awspg_pkg;

  // Defaults for the top-level parameters
  localparam int ADC_BITS_DEF       = 12;
  localparam int GAIN_FRAC_BITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // Fixed field widths
  localparam int BIN_W       = 3;
  localparam int PED_W       = 15;
  localparam int GAIN_W      = 10;
  localparam int OUT_W       = 19;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PEDESTAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN     = 2'd1;

  // Register reset values
  localparam logic [PED_W-1:0]  PEDESTAL_RESET = 15'd0;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 10'd64;

  // Time bins with a role in the window
  localparam logic [BIN_W-1:0] BIN_RESTART = 3'd0;
  localparam logic [BIN_W-1:0] BIN_PRE     = 3'd2;
  localparam logic [BIN_W-1:0] BIN_PEAK    = 3'd3;
  localparam logic [BIN_W-1:0] BIN_POST    = 3'd4;
  localparam logic [BIN_W-1:0] BIN_LAST    = 3'd7;

  // Peak flag bits
  localparam int             FLAG_RISE  = 0;
  localparam int             FLAG_FALL  = 1;
  localparam logic [1:0]     FLAGS_PEAK = 2'b11;
  localparam logic [1:0]     FLAGS_RISE_ONLY = 2'b01;

endpackage

`default_nettype wire

### sv/awspg_front.sv
// Front end: running window sum, peak flags and job classification.
`default_nettype none

module awspg_front #(
  parameter int ADC_BITS = awspg_pkg::ADC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [ADC_BITS-1:0]           adc_sample,
  input  wire logic [awspg_pkg::BIN_W-1:0]   time_bin,
  output logic      [ADC_BITS+2:0]           job_sum,
  output logic                               job_peak
);

  localparam int SUM_W = ADC_BITS + 3;

  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [ADC_BITS-1:0] previous_sample;
  logic [ADC_BITS-1:0] previous_sample_next;
  logic [1:0]          peak_flags;
  logic [1:0]          peak_flags_next;
  logic [SUM_W-1:0]    sample_ext;

  always_comb begin
    sample_ext           = SUM_W'(adc_sample);
    running_sum_next     = running_sum + sample_ext;
    previous_sample_next = previous_sample;
    peak_flags_next      = peak_flags;
    unique case (time_bin)
      awspg_pkg::BIN_RESTART: begin
        running_sum_next     = sample_ext;
        previous_sample_next = '0;
        peak_flags_next      = '0;
      end
      awspg_pkg::BIN_PRE: begin
        previous_sample_next = adc_sample;
      end
      awspg_pkg::BIN_PEAK: begin
        // a rise restarts the flags, dropping any earlier fall
        if (adc_sample >= previous_sample) begin
          peak_flags_next = awspg_pkg::FLAGS_RISE_ONLY;
        end
        previous_sample_next = adc_sample;
      end
      awspg_pkg::BIN_POST: begin
        if (adc_sample < previous_sample) begin
          peak_flags_next[awspg_pkg::FLAG_FALL] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Job for the back end: the updated sum, and whether this is a peaked last bin
  assign job_sum  = running_sum_next;
  assign job_peak = (time_bin == awspg_pkg::BIN_LAST) && (peak_flags == awspg_pkg::FLAGS_PEAK);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      previous_sample <= '0;
      peak_flags      <= '0;
    end else if (accept) begin
      running_sum     <= running_sum_next;
      previous_sample <= previous_sample_next;
      peak_flags      <= peak_flags_next;
    end
  end

endmodule

`default_nettype wire

### sv/awspg_queue.sv
// Short FIFO that decouples the front end from the back end.
`default_nettype none

module awspg_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = awspg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/awspg_back.sv
// Back end: pedestal subtract and clamp, gain multiply, output register.
`default_nettype none

module awspg_back #(
  parameter int ADC_BITS       = awspg_pkg::ADC_BITS_DEF,
  parameter int GAIN_FRAC_BITS = awspg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             job_valid,
  output logic                                  job_ready,
  input  wire logic [ADC_BITS+2:0]              job_sum,
  input  wire logic                             job_peak,
  input  wire logic [awspg_pkg::PED_W-1:0]      pedestal,
  input  wire logic [awspg_pkg::GAIN_W-1:0]     gain,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [awspg_pkg::OUT_W-1:0]      corrected_sum
);

  localparam int SUM_W  = ADC_BITS + 3;
  localparam int DIFF_W = (SUM_W > awspg_pkg::PED_W) ? SUM_W : awspg_pkg::PED_W;
  localparam int PROD_W = DIFF_W + awspg_pkg::GAIN_W;

  logic              s1_valid;
  logic [DIFF_W-1:0] s1_diff;
  logic              s1_ready;
  logic              out_ready;
  logic [DIFF_W-1:0] sum_ext;
  logic [DIFF_W-1:0] ped_ext;
  logic [DIFF_W-1:0] diff;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] scaled;

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign job_ready = s1_ready;

  always_comb begin
    sum_ext = DIFF_W'(job_sum);
    ped_ext = DIFF_W'(pedestal);
    diff    = '0;
    if (job_peak && (sum_ext > ped_ext)) begin
      diff = sum_ext - ped_ext;
    end
  end

  assign product = PROD_W'(s1_diff) * PROD_W'(gain);
  assign scaled  = product >> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= job_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_diff <= diff;
    end
    if (out_ready) begin
      corrected_sum <= scaled[awspg_pkg::OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/adc_window_sum_peak_gain.sv
// Top level of the ADC window sum, peak check and gain block.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   adc_sample, time_bin
//   out      output     out_valid / out_stall corrected_sum
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word in per cycle sustained while in_stall is low; every word gives exactly one result word.
// A taken word is written into the queue, then its pedestal-subtracted difference is
// loaded into the s1_diff stage, and then its gain product into the output register.
// Reset (rst, synchronous) clears the window state, the queue and the valids,
// and loads pedestal 0 and gain 64 (unity at the default GAIN_FRAC_BITS of 6).
// in_stall rises only when the queue is full; out_stall backs up the back end
// into the queue, while the front keeps taking words until the queue fills.
`default_nettype none

module adc_window_sum_peak_gain #(
  parameter int ADC_BITS       = awspg_pkg::ADC_BITS_DEF,
  parameter int GAIN_FRAC_BITS = awspg_pkg::GAIN_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = awspg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ADC_BITS-1:0]                 adc_sample,
  input  wire logic [awspg_pkg::BIN_W-1:0]         time_bin,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [awspg_pkg::OUT_W-1:0]         corrected_sum,
  // configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [awspg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [awspg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = ADC_BITS + 3;
  localparam int JOB_W = SUM_W + 1;

  logic [awspg_pkg::PED_W-1:0]  pedestal;
  logic [awspg_pkg::GAIN_W-1:0] gain;

  logic             accept;
  logic             queue_full;
  logic [SUM_W-1:0] front_sum;
  logic             front_peak;
  logic             job_valid;
  logic             job_ready;
  logic [JOB_W-1:0] job_word;

  // Configuration is always taken; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedestal <= awspg_pkg::PEDESTAL_RESET;
      gain     <= awspg_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        awspg_pkg::REG_PEDESTAL: pedestal <= cfg_data[awspg_pkg::PED_W-1:0];
        awspg_pkg::REG_GAIN:     gain     <= cfg_data[awspg_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a sample whenever the queue has room; the front end updates its
  // window state and pushes the job in the same cycle.
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  awspg_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .adc_sample (adc_sample),
    .time_bin   (time_bin),
    .job_sum    (front_sum),
    .job_peak   (front_peak)
  );

  awspg_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({front_peak, front_sum}),
    .full      (queue_full),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job_word)
  );

  // Back end: non-peaked jobs carry a zero difference and come out as zero.
  awspg_back #(
    .ADC_BITS       (ADC_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job_sum       (job_word[SUM_W-1:0]),
    .job_peak      (job_word[SUM_W]),
    .pedestal      (pedestal),
    .gain          (gain),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .corrected_sum (corrected_sum)
  );

endmodule

`default_nettype wire
